FILE: src/bic_pkg.sv
// shared constants, field widths and bank helper functions for the banked interrupt controller
package bic_pkg;

   // transaction field widths
   localparam int CMD_W  = 2;
   localparam int REG_W  = 4;
   localparam int DATA_W = 32;
   localparam int SRC_W  = 7;

   // bank organization
   localparam int NUM_BANKS = 3;
   localparam int BANK_W    = 32;

   // command codes
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_LINE  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_NOP   = 2'd3;

   // register indexes
   localparam logic [REG_W-1:0] REG_PEND0 = 4'd0;
   localparam logic [REG_W-1:0] REG_PEND1 = 4'd1;
   localparam logic [REG_W-1:0] REG_PEND2 = 4'd2;
   localparam logic [REG_W-1:0] REG_EN0   = 4'd3;
   localparam logic [REG_W-1:0] REG_EN1   = 4'd4;
   localparam logic [REG_W-1:0] REG_EN2   = 4'd5;
   localparam logic [REG_W-1:0] REG_DIS0  = 4'd6;
   localparam logic [REG_W-1:0] REG_DIS1  = 4'd7;
   localparam logic [REG_W-1:0] REG_DIS2  = 4'd8;

   typedef logic [NUM_BANKS-1:0][BANK_W-1:0] bank_vec_type;

   // first source number of a bank
   function automatic int bank_base(input int b, input int basic);
      int base;
      base = 0;
      if (b == 1) base = basic;
      if (b == 2) base = basic + BANK_W;
      return base;
   endfunction

   // number of sources held in a bank, clamped to 0..32
   function automatic int bank_width(input int b, input int num, input int basic);
      int base;
      int w;
      base = bank_base(b, basic);
      w = 0;
      if (num > base) begin
         w = num - base;
         if (b == 0 && w > basic) w = basic;
         if (w > BANK_W) w = BANK_W;
      end
      return w;
   endfunction

   // mask of the bits a bank actually holds
   function automatic logic [BANK_W-1:0] bank_mask(input int w);
      logic [BANK_W-1:0] m;
      m = '0;
      for (int i = 0; i < BANK_W; i++) begin
         if (i < w) m[i] = 1'b1;
      end
      return m;
   endfunction

endpackage

FILE: src/bic_req_if.sv
// request channel interface: valid/ready handshake with command payload
interface bic_req_if;
   import bic_pkg::*;

   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  command;
   logic [REG_W-1:0]  reg_index;
   logic [DATA_W-1:0] write_data;
   logic [SRC_W-1:0]  source_id;
   logic              level;

   modport source (output valid, command, reg_index, write_data, source_id, level,
                   input ready);
   modport sink   (input valid, command, reg_index, write_data, source_id, level,
                   output ready);
endinterface

FILE: src/bic_rsp_if.sv
// response channel interface: valid/ready handshake with result payload
interface bic_rsp_if;
   import bic_pkg::*;

   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] read_data;
   logic              irq_out;
   logic [SRC_W-1:0]  top_source;

   modport source (output valid, read_data, irq_out, top_source, input ready);
   modport sink   (input valid, read_data, irq_out, top_source, output ready);
endinterface

FILE: src/bic_prio.sv
// priority encoder: lowest pending enabled source across the three banks
module bic_prio #(
   parameter int NUM_SOURCES   = 72,
   parameter int BASIC_SOURCES = 8
) (
   input  bic_pkg::bank_vec_type      pending,
   output logic                       irq,
   output logic [bic_pkg::SRC_W-1:0]  top
);
   import bic_pkg::*;

   localparam int BASE1 = bank_base(1, BASIC_SOURCES);
   localparam int BASE2 = bank_base(2, BASIC_SOURCES);

   logic [NUM_BANKS-1:0] found;
   logic [NUM_BANKS-1:0][4:0] idx;

   // lowest set bit in each bank
   always_comb begin
      for (int b = 0; b < NUM_BANKS; b++) begin
         found[b] = |pending[b];
         idx[b]   = '0;
         for (int i = BANK_W - 1; i >= 0; i--) begin
            if (pending[b][i]) idx[b] = 5'(i);
         end
      end
   end

   // first non-empty bank wins
   always_comb begin
      irq = |found;
      if (found[0]) begin
         top = SRC_W'(idx[0]);
      end else if (found[1]) begin
         top = SRC_W'(BASE1) + SRC_W'(idx[1]);
      end else if (found[2]) begin
         top = SRC_W'(BASE2) + SRC_W'(idx[2]);
      end else begin
         top = SRC_W'(NUM_SOURCES);
      end
   end

endmodule

FILE: src/banked_interrupt_controller_unit.sv
// banked interrupt controller: request stage, bank state update, result stage
// path: an accepted transaction is held in the input register, then passes the
//   update logic into the result register, where its result is valid
// throughput: one transaction per cycle while the result side is not stalled; mask update
//   and priority encode are single-pass logic between the input and result registers
// reset: synchronous, clears all line levels and enables and empties both stages
module banked_interrupt_controller_unit #(
   parameter int NUM_SOURCES   = 72,
   parameter int BASIC_SOURCES = 8
) (
   input  logic       clock,
   input  logic       reset,
   bic_req_if.sink    req_chan,
   bic_rsp_if.source  rsp_chan
);
   import bic_pkg::*;

   localparam int W0 = bank_width(0, NUM_SOURCES, BASIC_SOURCES);
   localparam int W1 = bank_width(1, NUM_SOURCES, BASIC_SOURCES);
   localparam int W2 = bank_width(2, NUM_SOURCES, BASIC_SOURCES);
   localparam bank_vec_type BANK_VALID = {bank_mask(W2), bank_mask(W1), bank_mask(W0)};

   // input stage
   logic              s1_valid_ff;
   logic [CMD_W-1:0]  s1_cmd_ff;
   logic [REG_W-1:0]  s1_reg_ff;
   logic [DATA_W-1:0] s1_data_ff;
   logic [SRC_W-1:0]  s1_src_ff;
   logic              s1_level_ff;

   // bank state
   bank_vec_type line_ff, line_in;
   bank_vec_type en_ff, en_in;

   // result stage
   logic              rsp_valid_ff;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic              rsp_irq_ff;
   logic [SRC_W-1:0]  rsp_top_ff;

   logic              advance;
   logic              irq_next;
   logic [SRC_W-1:0]  top_next;
   bank_vec_type      pending_next;

   assign advance        = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || advance;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s1_valid_ff <= req_chan.valid;
      end
      if (req_chan.valid && req_chan.ready) begin
         s1_cmd_ff   <= req_chan.command;
         s1_reg_ff   <= req_chan.reg_index;
         s1_data_ff  <= req_chan.write_data;
         s1_src_ff   <= req_chan.source_id;
         s1_level_ff <= req_chan.level;
      end
   end

   // next bank state for the staged transaction
   always_comb begin
      line_in = line_ff;
      en_in   = en_ff;
      case (s1_cmd_ff)
         CMD_WRITE: begin
            if (s1_reg_ff inside {[REG_EN0:REG_EN2]}) begin
               for (int b = 0; b < NUM_BANKS; b++) begin
                  if (s1_reg_ff == REG_EN0 + REG_W'(b))
                     en_in[b] = (en_ff[b] | s1_data_ff) & BANK_VALID[b];
               end
            end else if (s1_reg_ff inside {[REG_DIS0:REG_DIS2]}) begin
               for (int b = 0; b < NUM_BANKS; b++) begin
                  if (s1_reg_ff == REG_DIS0 + REG_W'(b))
                     en_in[b] = en_ff[b] & ~s1_data_ff;
               end
            end
         end
         CMD_LINE: begin
            for (int b = 0; b < NUM_BANKS; b++) begin
               for (int i = 0; i < BANK_W; i++) begin
                  if (BANK_VALID[b][i] &&
                      int'(s1_src_ff) == bank_base(b, BASIC_SOURCES) + i)
                     line_in[b][i] = s1_level_ff;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // register read data
   always_comb begin
      rsp_data_in = '0;
      if (s1_cmd_ff == CMD_READ) begin
         case (s1_reg_ff)
            REG_PEND0:         rsp_data_in = line_ff[0] & en_ff[0];
            REG_PEND1:         rsp_data_in = line_ff[1] & en_ff[1];
            REG_PEND2:         rsp_data_in = line_ff[2] & en_ff[2];
            REG_EN0, REG_DIS0: rsp_data_in = en_ff[0];
            REG_EN1, REG_DIS1: rsp_data_in = en_ff[1];
            REG_EN2, REG_DIS2: rsp_data_in = en_ff[2];
            default:           rsp_data_in = '0;
         endcase
      end
   end

   // pending sources after the update
   always_comb begin
      for (int b = 0; b < NUM_BANKS; b++) begin
         pending_next[b] = line_in[b] & en_in[b];
      end
   end

   bic_prio #(
      .NUM_SOURCES   (NUM_SOURCES),
      .BASIC_SOURCES (BASIC_SOURCES)
   ) u_prio (
      .pending (pending_next),
      .irq     (irq_next),
      .top     (top_next)
   );

   // bank state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         line_ff      <= '0;
         en_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            line_ff      <= line_in;
            en_ff        <= en_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
         rsp_irq_ff  <= irq_next;
         rsp_top_ff  <= top_next;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.read_data  = rsp_data_ff;
   assign rsp_chan.irq_out    = rsp_irq_ff;
   assign rsp_chan.top_source = rsp_top_ff;

endmodule

FILE: bench/tb_banked_interrupt_controller_unit.sv
// self-checking testbench: directed and random bus and line traffic against a built-in predictor
`timescale 1ns / 100ps

module tb_banked_interrupt_controller_unit;
   import bic_pkg::*;

   localparam int NUM_SRC   = 72;
   localparam int BASIC_SRC = 8;
   localparam int MAX_PRINT = 100;

   // register indexes past the last real register
   localparam logic [REG_W-1:0] REG_HOLE_LO = REG_DIS2 + 1'b1;
   localparam logic [REG_W-1:0] REG_HOLE_HI = '1;
   localparam logic [SRC_W-1:0] SRC_NONE    = SRC_W'(NUM_SRC);
   localparam logic [SRC_W-1:0] SRC_TOP     = '1;

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic              irq;
      logic [SRC_W-1:0]  top;
   } irq_result_type;

   logic clock;
   logic reset;

   bic_req_if req_if ();
   bic_rsp_if rsp_if ();

   banked_interrupt_controller_unit #(
      .NUM_SOURCES   (NUM_SRC),
      .BASIC_SOURCES (BASIC_SRC)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // predicted controller state
   logic [BANK_W-1:0] line_state   [NUM_BANKS];
   logic [BANK_W-1:0] enable_state [NUM_BANKS];
   irq_result_type    irq_results_due [$];
   int                error_count = 0;
   bit                quiet_mode  = 1'b0;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("tb_banked_interrupt_controller_unit: FAIL");
      $finish;
   end

   // first source number held by a bank
   function automatic int first_source(input int b);
      int base;
      base = 0;
      if (b == 1) base = BASIC_SRC;
      if (b == 2) base = BASIC_SRC + BANK_W;
      return base;
   endfunction

   // number of sources a bank holds
   function automatic int bank_sources(input int b);
      int w;
      w = 0;
      if (NUM_SRC > first_source(b)) begin
         w = NUM_SRC - first_source(b);
         if (b == 0 && w > BASIC_SRC) w = BASIC_SRC;
         if (w > BANK_W) w = BANK_W;
      end
      return w;
   endfunction

   function automatic logic [BANK_W-1:0] held_bits(input int b);
      logic [BANK_W-1:0] m;
      m = '1;
      if (bank_sources(b) < BANK_W) m = (32'd1 << bank_sources(b)) - 32'd1;
      return m;
   endfunction

   // apply one transaction to the predicted state and build its result
   function automatic irq_result_type service_transaction(
      input logic [CMD_W-1:0]  cmd,
      input logic [REG_W-1:0]  ridx,
      input logic [DATA_W-1:0] wdata,
      input logic [SRC_W-1:0]  src,
      input logic              lvl
   );
      irq_result_type    r;
      int                b;
      int                pos;
      bit                found;
      logic [BANK_W-1:0] pend;
      r       = '0;
      r.top   = SRC_NONE;
      found   = 1'b0;
      case (cmd)
         CMD_READ: begin
            if (ridx <= REG_PEND2)
               r.read_data = line_state[ridx] & enable_state[ridx];
            else if (ridx <= REG_DIS2)
               r.read_data = enable_state[int'(ridx) % NUM_BANKS];
         end
         CMD_WRITE: begin
            if (ridx >= REG_EN0 && ridx <= REG_EN2) begin
               b = int'(ridx) - int'(REG_EN0);
               enable_state[b] = (enable_state[b] | wdata) & held_bits(b);
            end else if (ridx >= REG_DIS0 && ridx <= REG_DIS2) begin
               b = int'(ridx) - int'(REG_DIS0);
               enable_state[b] = enable_state[b] & ~wdata;
            end
         end
         CMD_LINE: begin
            // highest bank whose base is at or below the source owns it
            if (int'(src) < NUM_SRC) begin
               for (b = NUM_BANKS - 1; b >= 0; b--) begin
                  if (!found && int'(src) >= first_source(b)) begin
                     found = 1'b1;
                     pos   = int'(src) - first_source(b);
                     if (pos < bank_sources(b)) line_state[b][pos] = lvl;
                  end
               end
            end
         end
         default: ;
      endcase
      // lowest pending enabled source, basic bank first
      found = 1'b0;
      for (b = 0; b < NUM_BANKS; b++) begin
         pend = line_state[b] & enable_state[b] & held_bits(b);
         for (pos = 0; pos < BANK_W; pos++) begin
            if (!found && pend[pos]) begin
               found = 1'b1;
               r.top = SRC_W'(first_source(b) + pos);
            end
         end
      end
      r.irq = found;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                  input logic [DATA_W-1:0] want);
      error_count++;
      if (error_count <= MAX_PRINT)
         $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
   endtask

   // predict accepted requests, check accepted results
   always @(posedge clock) begin : result_checker
      irq_result_type want;
      if (!reset) begin
         if (req_if.valid && req_if.ready)
            irq_results_due.push_back(service_transaction(req_if.command, req_if.reg_index,
               req_if.write_data, req_if.source_id, req_if.level));
         if (rsp_if.valid && rsp_if.ready) begin
            if (irq_results_due.size() == 0) begin
               report_mismatch("unexpected result", rsp_if.read_data, '0);
            end else begin
               want = irq_results_due.pop_front();
               if (rsp_if.read_data !== want.read_data)
                  report_mismatch("read_data", rsp_if.read_data, want.read_data);
               if (rsp_if.irq_out !== want.irq)
                  report_mismatch("irq_out", 32'(rsp_if.irq_out), 32'(want.irq));
               if (rsp_if.top_source !== want.top)
                  report_mismatch("top_source", 32'(rsp_if.top_source), 32'(want.top));
            end
         end
      end
   end

   // result side: random stall before each result
   initial begin : result_receiver
      int stall;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = quiet_mode ? 0 : $urandom_range(0, 7);
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_if.valid) @(posedge clock);
      end
   end

   // send one request transaction after a random gap
   task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [REG_W-1:0] ridx,
                            input logic [DATA_W-1:0] wdata, input logic [SRC_W-1:0] src,
                            input logic lvl);
      int gap;
      gap = quiet_mode ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.command    <= cmd;
      req_if.reg_index  <= ridx;
      req_if.write_data <= wdata;
      req_if.source_id  <= src;
      req_if.level      <= lvl;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   function automatic logic [DATA_W-1:0] draw_mask();
      logic [DATA_W-1:0] m;
      case ($urandom_range(0, 3))
         0:       m = $urandom;
         1:       m = 32'd1 << $urandom_range(0, 31);
         2:       m = '1;
         default: m = $urandom & $urandom;
      endcase
      return m;
   endfunction

   // reset values of pending and enable registers
   task automatic test_reset_values();
      send_item(CMD_READ, REG_PEND0, '0, '0, 1'b0);
      send_item(CMD_READ, REG_EN1, '0, '0, 1'b0);
      send_item(CMD_READ, REG_DIS2, '0, '0, 1'b0);
   endtask

   // enable every bank fully, basic bank must clip to its width
   task automatic test_enable_readback();
      send_item(CMD_WRITE, REG_EN0, '1, '0, 1'b0);
      send_item(CMD_WRITE, REG_EN1, '1, '0, 1'b0);
      send_item(CMD_WRITE, REG_EN2, '1, '0, 1'b0);
      send_item(CMD_READ, REG_EN0, '0, '0, 1'b0);
   endtask

   // raise lines from the top down so the winner moves toward zero
   task automatic test_line_priority();
      send_item(CMD_LINE, '0, '0, SRC_W'(NUM_SRC - 1), 1'b1);
      send_item(CMD_LINE, '0, '0, SRC_W'(BASIC_SRC + BANK_W), 1'b1);
      send_item(CMD_LINE, '0, '0, SRC_W'(BASIC_SRC + BANK_W - 1), 1'b1);
      send_item(CMD_LINE, '0, '0, SRC_W'(BASIC_SRC), 1'b1);
      send_item(CMD_LINE, '0, '0, SRC_W'(BASIC_SRC - 1), 1'b1);
      send_item(CMD_LINE, '0, '0, '0, 1'b1);
      send_item(CMD_READ, REG_PEND0, '0, '0, 1'b0);
      send_item(CMD_READ, REG_PEND1, '0, '0, 1'b0);
      send_item(CMD_READ, REG_PEND2, '0, '0, 1'b0);
   endtask

   // disables, line drop and out-of-range sources
   task automatic test_disable_lines();
      send_item(CMD_WRITE, REG_DIS0, '1, '0, 1'b0);
      send_item(CMD_LINE, '0, '0, '0, 1'b0);
      send_item(CMD_LINE, '0, '0, SRC_NONE, 1'b1);
      send_item(CMD_LINE, '0, '0, SRC_TOP, 1'b1);
      send_item(CMD_WRITE, REG_DIS1, '1, '0, 1'b0);
      send_item(CMD_READ, REG_EN2, '0, '0, 1'b0);
   endtask

   // accesses that must leave state alone, followed by a full disable of the top bank
   task automatic test_ignored_accesses();
      send_item(CMD_WRITE, REG_PEND2, '1, '0, 1'b0);
      send_item(CMD_WRITE, REG_HOLE_HI, '1, '0, 1'b0);
      send_item(CMD_READ, REG_HOLE_LO, '0, '0, 1'b0);
      send_item(CMD_NOP, REG_EN1, '1, SRC_TOP, 1'b1);
      send_item(CMD_WRITE, REG_DIS2, '1, '0, 1'b0);
   endtask

   // mostly meaningful traffic, some noise, phases with and without idling
   task automatic test_random_traffic(input int count);
      int                pick;
      logic [CMD_W-1:0]  cmd;
      logic [REG_W-1:0]  ridx;
      logic [DATA_W-1:0] wdata;
      logic [SRC_W-1:0]  src;
      logic              lvl;
      for (int i = 0; i < count; i++) begin
         if (i % 100 == 0) quiet_mode = ($urandom_range(0, 3) == 0);
         pick  = $urandom_range(0, 99);
         wdata = $urandom;
         src   = SRC_W'($urandom_range(0, 127));
         lvl   = 1'($urandom_range(0, 1));
         ridx  = REG_W'($urandom_range(0, 15));
         if (pick < 45) begin
            cmd  = CMD_LINE;
            if ($urandom_range(0, 99) < 95) src = SRC_W'($urandom_range(0, NUM_SRC - 1));
         end else if (pick < 65) begin
            cmd   = CMD_WRITE;
            ridx  = REG_EN0 + REG_W'($urandom_range(0, 2));
            wdata = draw_mask();
         end else if (pick < 75) begin
            cmd   = CMD_WRITE;
            ridx  = REG_DIS0 + REG_W'($urandom_range(0, 2));
            wdata = draw_mask();
         end else if (pick < 90) begin
            cmd  = CMD_READ;
            ridx = REG_PEND0 + REG_W'($urandom_range(0, 8));
         end else begin
            // noise: no-ops, pending writes, unmapped indexes
            case ($urandom_range(0, 2))
               0:       cmd = CMD_NOP;
               1: begin
                  cmd  = CMD_WRITE;
                  ridx = REG_PEND0 + REG_W'($urandom_range(0, 2));
               end
               default: begin
                  cmd  = $urandom_range(0, 1) ? CMD_READ : CMD_WRITE;
                  ridx = REG_W'($urandom_range(int'(REG_HOLE_LO), int'(REG_HOLE_HI)));
               end
            endcase
         end
         send_item(cmd, ridx, wdata, src, lvl);
      end
      quiet_mode = 1'b0;
   endtask

   // test sequence
   initial begin
      reset             <= 1'b1;
      req_if.valid      <= 1'b0;
      req_if.command    <= CMD_NOP;
      req_if.reg_index  <= REG_PEND0;
      req_if.write_data <= '0;
      req_if.source_id  <= '0;
      req_if.level      <= 1'b0;
      for (int b = 0; b < NUM_BANKS; b++) begin
         line_state[b]   = '0;
         enable_state[b] = '0;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_reset_values();
      test_enable_readback();
      test_line_priority();
      test_disable_lines();
      test_ignored_accesses();
      test_random_traffic(1500);
      req_if.valid <= 1'b0;

      // drain, then allow for the result stage
      while (irq_results_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (irq_results_due.size() != 0)
         report_mismatch("missing results", 32'(irq_results_due.size()), '0);

      if (error_count == 0) begin
         $display("tb_banked_interrupt_controller_unit: PASS");
      end else begin
         $display("tb_banked_interrupt_controller_unit: FAIL");
      end
      $finish;
   end

endmodule
